>>> rtl/i2cm_pkg.sv
`timescale 1ns / 1ps

package i2cm_pkg;

    localparam int ADDR_W  = 7;
    localparam int COUNT_W = 16;
    localparam int BYTE_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_HALF = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 2'd2;

    localparam logic [ADDR_W-1:0]  RST_TARGET_ADDRESS = 7'h08;
    localparam logic [COUNT_W-1:0] RST_TICKS_PER_HALF = 16'd100;
    localparam logic [COUNT_W-1:0] RST_ACK_TIMEOUT = 16'd50;

    typedef struct packed {
        logic [ADDR_W-1:0]  target_address;
        logic [COUNT_W-1:0] ticks_per_half_bit;
        logic [COUNT_W-1:0] ack_timeout_ticks;
    } i2cm_cfg_t;

    typedef struct packed {
        logic start_request;
        logic mode;
        logic [BYTE_W-1:0] write_data;
        logic sda_sample;
    } i2cm_tick_t;

    typedef struct packed {
        logic scl_level;
        logic sda_pull_low;
        logic busy_res;
        logic done_res;
        logic address_acked;
        logic data_acked;
        logic [BYTE_W-1:0] read_byte;
    } i2cm_result_t;

endpackage

>>> rtl/i2cm_seq.sv
`timescale 1ns / 1ps

module i2cm_seq
    import i2cm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  i2cm_tick_t   tick,
    input  i2cm_cfg_t    cfg,
    output i2cm_result_t result
);

    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_START_HI = 4'd1;
    localparam logic [3:0] PH_START_LO = 4'd2;
    localparam logic [3:0] PH_BIT_LO   = 4'd3;
    localparam logic [3:0] PH_BIT_HI   = 4'd4;
    localparam logic [3:0] PH_ACK_LO   = 4'd5;
    localparam logic [3:0] PH_ACK_HI   = 4'd6;
    localparam logic [3:0] PH_STOP_LO  = 4'd7;
    localparam logic [3:0] PH_STOP_HI  = 4'd8;
    localparam logic [3:0] PH_STOP_REL = 4'd9;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    logic [3:0]         phase_reg, phase_next;
    logic [3:0]         bit_pos_reg, bit_pos_next;
    logic [COUNT_W-1:0] half_cnt_reg, half_cnt_next;
    logic [COUNT_W-1:0] ack_cnt_reg, ack_cnt_next;
    logic [BYTE_W-1:0]  shift_reg, shift_next;
    logic               read_mode_reg, read_mode_next;
    logic [1:0]         ack_flags_reg, ack_flags_next;
    logic [BYTE_W-1:0]  data_byte_reg, data_byte_next;
    logic               data_stage_reg, data_stage_next;
    logic [BYTE_W-1:0]  read_result_reg, read_result_next;

    logic [COUNT_W-1:0] half_len;
    logic [COUNT_W-1:0] ack_len;
    logic               half_last;
    logic [COUNT_W-1:0] half_cnt_adv;
    logic               reading;
    logic               bit_pull;
    logic [BYTE_W-1:0]  shifted;
    logic [3:0]         bit_pos_inc;
    logic               ack_seen;
    logic               ack_end;
    logic               scl, pull, busy, done;

    // a zero timing register counts as one tick
    assign half_len = (cfg.ticks_per_half_bit == '0) ? COUNT_W'(1) : cfg.ticks_per_half_bit;
    assign ack_len  = (cfg.ack_timeout_ticks == '0) ? COUNT_W'(1) : cfg.ack_timeout_ticks;

    assign half_last    = ({1'b0, half_cnt_reg} + 17'd1) >= {1'b0, half_len};
    assign half_cnt_adv = half_last ? '0 : half_cnt_reg + COUNT_W'(1);

    assign reading     = read_mode_reg & data_stage_reg;
    assign bit_pull    = reading ? 1'b0 : ~shift_reg[BYTE_W-1];
    assign shifted     = {shift_reg[BYTE_W-2:0], reading & tick.sda_sample};
    assign bit_pos_inc = bit_pos_reg + 4'd1;
    assign ack_seen    = ~tick.sda_sample;
    assign ack_end     = ack_seen | (({1'b0, ack_cnt_reg} + 17'd1) >= {1'b0, ack_len});

    always_comb
    begin
        phase_next       = phase_reg;
        bit_pos_next     = bit_pos_reg;
        half_cnt_next    = half_cnt_reg;
        ack_cnt_next     = ack_cnt_reg;
        shift_next       = shift_reg;
        read_mode_next   = read_mode_reg;
        ack_flags_next   = ack_flags_reg;
        data_byte_next   = data_byte_reg;
        data_stage_next  = data_stage_reg;
        read_result_next = read_result_reg;
        scl  = 1'b1;
        pull = 1'b0;
        busy = 1'b1;
        done = 1'b0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                busy = 1'b0;
                if (tick.start_request)
                begin
                    read_mode_next   = tick.mode;
                    data_byte_next   = tick.write_data;
                    shift_next       = {cfg.target_address, tick.mode};
                    data_stage_next  = 1'b0;
                    bit_pos_next     = '0;
                    half_cnt_next    = '0;
                    ack_cnt_next     = '0;
                    ack_flags_next   = '0;
                    read_result_next = '0;
                    phase_next       = PH_START_HI;
                end
            end
            PH_START_HI:
            begin
                pull = 1'b1;
                half_cnt_next = half_cnt_adv;
                if (half_last) phase_next = PH_START_LO;
            end
            PH_START_LO:
            begin
                scl  = 1'b0;
                pull = 1'b1;
                half_cnt_next = half_cnt_adv;
                if (half_last) phase_next = PH_BIT_LO;
            end
            PH_BIT_LO:
            begin
                scl  = 1'b0;
                pull = bit_pull;
                half_cnt_next = half_cnt_adv;
                if (half_last) phase_next = PH_BIT_HI;
            end
            PH_BIT_HI:
            begin
                pull = bit_pull;
                half_cnt_next = half_cnt_adv;
                if (half_last)
                begin
                    shift_next = shifted;
                    if (bit_pos_inc >= BITS_PER_BYTE)
                    begin
                        bit_pos_next = '0;
                        if (reading) read_result_next = shifted;
                        phase_next = PH_ACK_LO;
                    end
                    else
                    begin
                        bit_pos_next = bit_pos_inc;
                        phase_next   = PH_BIT_LO;
                    end
                end
            end
            PH_ACK_LO:
            begin
                scl = 1'b0;
                half_cnt_next = half_cnt_adv;
                if (half_last)
                begin
                    ack_cnt_next = '0;
                    phase_next   = PH_ACK_HI;
                end
            end
            PH_ACK_HI:
            begin
                if (reading)
                begin
                    // master NACK: SDA stays released for the whole half
                    half_cnt_next = half_cnt_adv;
                    if (half_last) phase_next = PH_STOP_LO;
                end
                else if (!ack_end)
                begin
                    ack_cnt_next = ack_cnt_reg + COUNT_W'(1);
                end
                else
                begin
                    ack_cnt_next  = '0;
                    half_cnt_next = '0;
                    if (!data_stage_reg)
                    begin
                        if (ack_seen)
                        begin
                            ack_flags_next[0] = 1'b1;
                            data_stage_next   = 1'b1;
                            shift_next = read_mode_reg ? '0 : data_byte_reg;
                            phase_next = PH_BIT_LO;
                        end
                        else
                        begin
                            // address NACK skips the data byte
                            phase_next = PH_STOP_LO;
                        end
                    end
                    else
                    begin
                        if (ack_seen) ack_flags_next[1] = 1'b1;
                        phase_next = PH_STOP_LO;
                    end
                end
            end
            PH_STOP_LO:
            begin
                scl  = 1'b0;
                pull = 1'b1;
                half_cnt_next = half_cnt_adv;
                if (half_last) phase_next = PH_STOP_HI;
            end
            PH_STOP_HI:
            begin
                pull = 1'b1;
                half_cnt_next = half_cnt_adv;
                if (half_last) phase_next = PH_STOP_REL;
            end
            PH_STOP_REL:
            begin
                half_cnt_next = half_cnt_adv;
                if (half_last)
                begin
                    done       = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                busy          = 1'b0;
                phase_next    = PH_IDLE;
                half_cnt_next = '0;
            end
        endcase
    end

    assign result.scl_level     = scl;
    assign result.sda_pull_low  = pull;
    assign result.busy_res      = busy;
    assign result.done_res      = done;
    assign result.address_acked = ack_flags_next[0];
    assign result.data_acked    = ack_flags_next[1];
    assign result.read_byte     = read_result_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            bit_pos_reg     <= '0;
            half_cnt_reg    <= '0;
            ack_cnt_reg     <= '0;
            shift_reg       <= '0;
            read_mode_reg   <= 1'b0;
            ack_flags_reg   <= '0;
            data_byte_reg   <= '0;
            data_stage_reg  <= 1'b0;
            read_result_reg <= '0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            bit_pos_reg     <= bit_pos_next;
            half_cnt_reg    <= half_cnt_next;
            ack_cnt_reg     <= ack_cnt_next;
            shift_reg       <= shift_next;
            read_mode_reg   <= read_mode_next;
            ack_flags_reg   <= ack_flags_next;
            data_byte_reg   <= data_byte_next;
            data_stage_reg  <= data_stage_next;
            read_result_reg <= read_result_next;
        end
    end

endmodule

>>> rtl/i2c_single_byte_master_top.sv
`timescale 1ns / 1ps

// Channel | Handshake           | Payload
// --------+---------------------+-----------------------------------------------
// in      | in_valid / in_ready | start_request, mode, write_data, sda_sample
// out     | out_valid/out_ready | scl_level, sda_pull_low, busy_res, done_res,
//         |                     | address_acked, data_acked, read_byte
// cfg     | cfg_we (no wait)    | cfg_index, cfg_data
//
// One request (one bus tick) per clock while in_ready is high: the sequencer
// state advances in the cycle a request is accepted and its result lands in
// the output register. in_ready is high while the output register is empty
// or being drained, so a stall on out holds only while out_ready stays low.
// Reset puts the sequencer in idle and loads the register defaults
// (address 0x08, 100 ticks per half bit, 50 ticks ACK timeout).

module i2c_single_byte_master_top
    import i2cm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  start_request,
    input  logic                  mode,
    input  logic [BYTE_W-1:0]     write_data,
    input  logic                  sda_sample,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  scl_level,
    output logic                  sda_pull_low,
    output logic                  busy_res,
    output logic                  done_res,
    output logic                  address_acked,
    output logic                  data_acked,
    output logic [BYTE_W-1:0]     read_byte
);

    logic [ADDR_W-1:0]  target_address_reg;
    logic [COUNT_W-1:0] ticks_per_half_reg;
    logic [COUNT_W-1:0] ack_timeout_reg;

    logic         out_valid_reg;
    i2cm_result_t result_reg;

    i2cm_cfg_t    cfg;
    i2cm_tick_t   tick;
    i2cm_result_t seq_result;
    logic         accept;

    // Register file; writes to indexes past the last register are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_address_reg <= RST_TARGET_ADDRESS;
            ticks_per_half_reg <= RST_TICKS_PER_HALF;
            ack_timeout_reg    <= RST_ACK_TIMEOUT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TARGET_ADDRESS: target_address_reg <= cfg_data[ADDR_W-1:0];
                CFG_TICKS_PER_HALF: ticks_per_half_reg <= cfg_data[COUNT_W-1:0];
                CFG_ACK_TIMEOUT:    ack_timeout_reg    <= cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.target_address     = target_address_reg;
    assign cfg.ticks_per_half_bit = ticks_per_half_reg;
    assign cfg.ack_timeout_ticks  = ack_timeout_reg;

    assign tick.start_request = start_request;
    assign tick.mode          = mode;
    assign tick.write_data    = write_data;
    assign tick.sda_sample    = sda_sample;

    // Take a new request whenever the output slot is free or emptying now.
    assign in_ready = ~out_valid_reg | out_ready;
    assign accept   = in_valid & in_ready;

    i2cm_seq u_seq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (accept),
        .tick   (tick),
        .cfg    (cfg),
        .result (seq_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // payload needs no reset; it is qualified by out_valid
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= seq_result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign scl_level     = result_reg.scl_level;
    assign sda_pull_low  = result_reg.sda_pull_low;
    assign busy_res      = result_reg.busy_res;
    assign done_res      = result_reg.done_res;
    assign address_acked = result_reg.address_acked;
    assign data_acked    = result_reg.data_acked;
    assign read_byte     = result_reg.read_byte;

endmodule
